/* hdl/tcw_pkg.sv */
// Shared constants, codes and types of the text console writer.
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 4;
    localparam int CELLS    = COLUMNS * ROWS;

    // Field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int OFF_W  = 11;
    localparam int CHR_W  = 8;
    localparam int ACT_W  = 2;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int TAB_W  = $clog2(TAB_STOP);
    localparam int TCNT_W = $clog2(TAB_STOP + 1);

    // Derived addresses
    localparam logic [ADDR_W-1:0] SCROLL_LEN   = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW_OFF = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] COLS_ADDR    = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL     = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW     = ROW_W'(ROWS - 1);
    localparam logic [TAB_W-1:0]  LAST_PHASE   = TAB_W'(TAB_STOP - 1);

    // Character codes
    localparam logic [CHR_W-1:0] CHR_NL    = 8'h0A;
    localparam logic [CHR_W-1:0] CHR_CR    = 8'h0D;
    localparam logic [CHR_W-1:0] CHR_TAB   = 8'h09;
    localparam logic [CHR_W-1:0] CHR_SPACE = 8'h20;

    localparam logic [CHR_W-1:0] DEFAULT_COLOR_RST = 8'h07;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_SCROLL,
        S_CLRROW,
        S_CLEAR,
        S_EMIT
    } t_state;

    // Access to the character and color memories
    typedef struct packed {
        logic              we_char;
        logic              we_color;
        logic [ADDR_W-1:0] waddr;
        logic [CHR_W-1:0]  wchar;
        logic [CHR_W-1:0]  wcolor;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // Finished transaction handed to the output register
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [OFF_W-1:0] off;
        logic             rd_ok;
    } t_result;

endpackage

/* hdl/tcw_ram.sv */
// Generic simple dual-port RAM with registered read.
module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/tcw_ctrl.sv */
// Sequencer: cursor, tab expansion, scroll and clear sweeps, memory addressing.
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CHR_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [CHR_W-1:0]  i_chr,
    input  logic [COL_W-1:0]  i_cell_col,
    input  logic [ROW_W-1:0]  i_cell_row,
    input  logic [CHR_W-1:0]  i_rd_char,
    input  logic [CHR_W-1:0]  i_rd_color,
    input  logic              i_slot_free,
    output t_mem_req          o_mem,
    output logic              o_emit,
    output t_result           o_result
);

    t_state              r_state, n_state;
    logic [COL_W-1:0]    r_cur_col, n_cur_col;
    logic [ROW_W-1:0]    r_cur_row, n_cur_row;
    logic [ADDR_W-1:0]   r_cur_off, n_cur_off;
    logic [TAB_W-1:0]    r_phase, n_phase;
    logic [TCNT_W-1:0]   r_tab_left, n_tab_left;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic                r_rd_ok, n_rd_ok;
    logic [CHR_W-1:0]    r_default_color;

    logic                accept;
    t_action             act;
    logic                is_last_row;
    logic [COL_W-1:0]    adv_col;
    logic [ROW_W-1:0]    adv_row;
    logic [ADDR_W-1:0]   adv_off;
    logic [TAB_W-1:0]    adv_phase;
    logic                adv_scroll;
    logic [ROW_W-1:0]    nl_row;
    logic [ADDR_W-1:0]   nl_off;
    logic [ADDR_W-1:0]   cr_off;
    logic [ADDR_W-1:0]   rd_addr;
    logic                rd_in_range;

    assign accept = i_in_valid && o_in_ready;
    assign act    = t_action'(i_action);

    // Cursor after one printable character, newline or carriage return
    always_comb begin
        is_last_row = (r_cur_row == LAST_ROW);
        adv_scroll  = 1'b0;
        if (r_cur_col != LAST_COL) begin
            adv_col   = r_cur_col + 1'b1;
            adv_row   = r_cur_row;
            adv_off   = r_cur_off + 1'b1;
            adv_phase = (r_phase == LAST_PHASE) ? '0 : r_phase + 1'b1;
        end else if (!is_last_row) begin
            adv_col   = '0;
            adv_row   = r_cur_row + 1'b1;
            adv_off   = r_cur_off + 1'b1;
            adv_phase = '0;
        end else begin
            adv_col    = '0;
            adv_row    = LAST_ROW;
            adv_off    = LAST_ROW_OFF;
            adv_phase  = '0;
            adv_scroll = 1'b1;
        end
        cr_off = r_cur_off - ADDR_W'(r_cur_col);
        if (is_last_row) begin
            nl_row = LAST_ROW;
            nl_off = LAST_ROW_OFF;
        end else begin
            nl_row = r_cur_row + 1'b1;
            nl_off = cr_off + COLS_ADDR;
        end
    end

    // Address of the cell to read
    assign rd_addr     = ADDR_W'(i_cell_row * COLUMNS) + ADDR_W'(i_cell_col);
    assign rd_in_range = (i_cell_col < COL_W'(COLUMNS)) && (i_cell_row < ROW_W'(ROWS));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (r_addr == LAST_ADDR) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (act)
                        ACT_PUT: begin
                            priority if (i_chr == CHR_NL) begin
                                n_state = is_last_row ? S_SCROLL : S_EMIT;
                            end else if (i_chr == CHR_CR) begin
                                n_state = S_EMIT;
                            end else if (i_chr == CHR_TAB) begin
                                n_state = S_PUT;
                            end else begin
                                n_state = adv_scroll ? S_SCROLL : S_EMIT;
                            end
                        end
                        ACT_CLEAR: n_state = S_CLEAR;
                        ACT_READ:  n_state = S_EMIT;
                        ACT_NONE:  n_state = S_EMIT;
                    endcase
                end
            end
            S_PUT: begin
                if (adv_scroll) begin
                    n_state = S_SCROLL;
                end else if (r_tab_left == TCNT_W'(1)) begin
                    n_state = S_EMIT;
                end
            end
            S_SCROLL: begin
                if (r_addr == SCROLL_LEN) n_state = S_CLRROW;
            end
            S_CLRROW: begin
                if (r_addr == LAST_ADDR) begin
                    n_state = (r_tab_left != '0) ? S_PUT : S_EMIT;
                end
            end
            S_CLEAR: begin
                if (r_addr == LAST_ADDR) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_slot_free) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    // Memory access, cursor and counter updates
    always_comb begin
        n_cur_col  = r_cur_col;
        n_cur_row  = r_cur_row;
        n_cur_off  = r_cur_off;
        n_phase    = r_phase;
        n_tab_left = r_tab_left;
        n_addr     = r_addr;
        n_rd_ok    = r_rd_ok;
        o_mem      = '0;
        o_in_ready = 1'b0;
        o_emit     = 1'b0;
        unique case (r_state)
            S_INIT, S_CLEAR, S_CLRROW: begin
                o_mem.we_char  = 1'b1;
                o_mem.we_color = 1'b1;
                o_mem.waddr    = r_addr;
                o_mem.wchar    = '0;
                o_mem.wcolor   = r_default_color;
                n_addr         = (r_addr == LAST_ADDR) ? '0 : r_addr + 1'b1;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    n_rd_ok    = 1'b0;
                    n_tab_left = '0;
                    n_addr     = '0;
                    unique case (act)
                        ACT_PUT: begin
                            priority if (i_chr == CHR_NL) begin
                                n_cur_col = '0;
                                n_cur_row = nl_row;
                                n_cur_off = nl_off;
                                n_phase   = '0;
                            end else if (i_chr == CHR_CR) begin
                                n_cur_col = '0;
                                n_cur_off = cr_off;
                                n_phase   = '0;
                            end else if (i_chr == CHR_TAB) begin
                                n_tab_left = TCNT_W'(TAB_STOP) - TCNT_W'(r_phase);
                            end else begin
                                o_mem.we_char = 1'b1;
                                o_mem.waddr   = r_cur_off;
                                o_mem.wchar   = i_chr;
                                n_cur_col     = adv_col;
                                n_cur_row     = adv_row;
                                n_cur_off     = adv_off;
                                n_phase       = adv_phase;
                            end
                        end
                        ACT_CLEAR: begin
                            n_cur_col = '0;
                            n_cur_row = '0;
                            n_cur_off = '0;
                            n_phase   = '0;
                        end
                        ACT_READ: begin
                            n_rd_ok     = rd_in_range;
                            o_mem.re    = rd_in_range;
                            o_mem.raddr = rd_addr;
                        end
                        ACT_NONE: begin
                            n_rd_ok = 1'b0;
                        end
                    endcase
                end
            end
            S_PUT: begin
                // Emit one space of the tab
                o_mem.we_char = 1'b1;
                o_mem.waddr   = r_cur_off;
                o_mem.wchar   = CHR_SPACE;
                n_cur_col     = adv_col;
                n_cur_row     = adv_row;
                n_cur_off     = adv_off;
                n_phase       = adv_phase;
                n_tab_left    = r_tab_left - 1'b1;
                n_addr        = '0;
            end
            S_SCROLL: begin
                // Read one row ahead, write back the cell read last cycle
                if (r_addr != SCROLL_LEN) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_addr + COLS_ADDR;
                end
                if (r_addr != '0) begin
                    o_mem.we_char  = 1'b1;
                    o_mem.we_color = 1'b1;
                    o_mem.waddr    = r_addr - 1'b1;
                    o_mem.wchar    = i_rd_char;
                    o_mem.wcolor   = i_rd_color;
                end
                n_addr = (r_addr == SCROLL_LEN) ? r_addr : r_addr + 1'b1;
            end
            S_EMIT: begin
                o_emit = i_slot_free;
            end
            default: begin
                n_addr = '0;
            end
        endcase
    end

    assign o_result.col   = r_cur_col;
    assign o_result.row   = r_cur_row;
    assign o_result.off   = OFF_W'(r_cur_off);
    assign o_result.rd_ok = r_rd_ok;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_INIT;
            r_cur_col       <= '0;
            r_cur_row       <= '0;
            r_cur_off       <= '0;
            r_phase         <= '0;
            r_tab_left      <= '0;
            r_addr          <= '0;
            r_rd_ok         <= 1'b0;
            r_default_color <= DEFAULT_COLOR_RST;
        end else begin
            r_state    <= n_state;
            r_cur_col  <= n_cur_col;
            r_cur_row  <= n_cur_row;
            r_cur_off  <= n_cur_off;
            r_phase    <= n_phase;
            r_tab_left <= n_tab_left;
            r_addr     <= n_addr;
            r_rd_ok    <= n_rd_ok;
            if (i_cfg_we) begin
                r_default_color <= i_cfg_wdata;
            end
        end
    end

    // Offset register tracks row and column
    a_off_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_off == ADDR_W'(r_cur_row * COLUMNS) + ADDR_W'(r_cur_col))
        else $error("cursor offset out of step with row and column");

    // Cursor stays on screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_col < COL_W'(COLUMNS)) && (r_cur_row < ROW_W'(ROWS)))
        else $error("cursor left the screen");

    // Copy sweep hands over to bottom row clear at the right cell
    a_scroll_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL && r_addr == SCROLL_LEN)
        |=> (r_state == S_CLRROW && r_addr == SCROLL_LEN))
        else $error("scroll copy did not hand over to row clear");

    // A cell read reaches the result stage in the following cycle
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && act == ACT_READ) |=> (r_state == S_EMIT))
        else $error("cell read did not reach result stage");

    // Writes stay inside the store
    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem.we_char || o_mem.we_color) |-> (o_mem.waddr <= LAST_ADDR))
        else $error("memory write outside the store");

endmodule

/* hdl/text_console_writer.sv */
// Top level of the text console writer: memories, sequencer and output register.
//
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_ready     i_action i_chr i_cell_col i_cell_row
//  result    out        o_out_valid / i_out_ready   o_cursor_col o_cursor_row
//                                                   o_cursor_offset o_cell_char o_cell_color
//  config    in         i_cfg_we (no wait)          i_cfg_wdata (default color)
//
//  Put character, carriage return, newline, read cell and unused action go from the
//  accepting state to the result stage; a tab first writes each space it emits.
//  Any scroll adds a row copy through the single memory read port, then a clear of
//  the bottom row. Clear screen adds a sweep of the whole store.
//  After reset the store is swept once with o_in_ready low.
//  A result waits in the output register while the next transaction is already taken;
//  the sequencer stalls only when it finishes a second one before the first is taken.
module text_console_writer
    import tcw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CHR_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [ACT_W-1:0] i_action,
    input  logic [CHR_W-1:0] i_chr,
    input  logic [COL_W-1:0] i_cell_col,
    input  logic [ROW_W-1:0] i_cell_row,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [COL_W-1:0] o_cursor_col,
    output logic [ROW_W-1:0] o_cursor_row,
    output logic [OFF_W-1:0] o_cursor_offset,
    output logic [CHR_W-1:0] o_cell_char,
    output logic [CHR_W-1:0] o_cell_color
);

    t_mem_req         mem_req;
    t_result          result;
    logic             emit;
    logic             slot_free;
    logic [CHR_W-1:0] rd_char;
    logic [CHR_W-1:0] rd_color;

    logic             r_out_valid;
    logic [COL_W-1:0] r_out_col;
    logic [ROW_W-1:0] r_out_row;
    logic [OFF_W-1:0] r_out_off;
    logic [CHR_W-1:0] r_out_char;
    logic [CHR_W-1:0] r_out_color;

    assign slot_free = !r_out_valid || i_out_ready;

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_chr       (i_chr),
        .i_cell_col  (i_cell_col),
        .i_cell_row  (i_cell_row),
        .i_rd_char   (rd_char),
        .i_rd_color  (rd_color),
        .i_slot_free (slot_free),
        .o_mem       (mem_req),
        .o_emit      (emit),
        .o_result    (result)
    );

    tcw_ram #(.WIDTH(CHR_W), .DEPTH(CELLS)) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we_char),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wchar),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (rd_char)
    );

    tcw_ram #(.WIDTH(CHR_W), .DEPTH(CELLS)) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we_color),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wcolor),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (rd_color)
    );

    // Output valid: set on a finished transaction, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload: capture cursor and read data, zero cell for other actions
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_col   <= result.col;
            r_out_row   <= result.row;
            r_out_off   <= result.off;
            r_out_char  <= result.rd_ok ? rd_char : '0;
            r_out_color <= result.rd_ok ? rd_color : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cursor_col    = r_out_col;
    assign o_cursor_row    = r_out_row;
    assign o_cursor_offset = r_out_off;
    assign o_cell_char     = r_out_char;
    assign o_cell_color    = r_out_color;

endmodule

/* dv/tb_text_console_writer.sv */
// Self-checking testbench for the text console writer: directed and random traffic, shadow screen.
module tb_text_console_writer
    import tcw_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD   = 3000;
    localparam int PHASE_ITEMS = 180;
    localparam int N_PHASES    = 5;

    typedef struct {
        t_action          action;
        logic [CHR_W-1:0] chr;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_console_cmd;

    typedef struct {
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
        logic [OFF_W-1:0] cursor_offset;
        logic [CHR_W-1:0] cell_char;
        logic [CHR_W-1:0] cell_color;
    } t_console_res;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [CHR_W-1:0] i_cfg_wdata = '0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    logic [ACT_W-1:0] i_action    = '0;
    logic [CHR_W-1:0] i_chr       = '0;
    logic [COL_W-1:0] i_cell_col  = '0;
    logic [ROW_W-1:0] i_cell_row  = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [COL_W-1:0] o_cursor_col;
    logic [ROW_W-1:0] o_cursor_row;
    logic [OFF_W-1:0] o_cursor_offset;
    logic [CHR_W-1:0] o_cell_char;
    logic [CHR_W-1:0] o_cell_color;

    text_console_writer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_chr           (i_chr),
        .i_cell_col      (i_cell_col),
        .i_cell_row      (i_cell_row),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_cursor_col    (o_cursor_col),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_offset (o_cursor_offset),
        .o_cell_char     (o_cell_char),
        .o_cell_color    (o_cell_color)
    );

    always #1 i_clk = ~i_clk;

    // Shadow screen and cursor
    logic [CHR_W-1:0] screen_char  [CELLS];
    logic [CHR_W-1:0] screen_color [CELLS];
    int               shadow_col;
    int               shadow_row;
    logic [CHR_W-1:0] shadow_color;

    t_console_cmd pending_cmds [$];
    t_console_res expected_res [$];
    t_console_cmd offered_cmd;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit long_hold_req  = 1'b0;
    int hold_left      = 0;
    int fail_count     = 0;
    int newline_budget = 250;
    int clear_budget   = 20;

    int          phase_send  [N_PHASES] = '{0, 65, 0, 7, 30};
    int          phase_recv  [N_PHASES] = '{0, 0, 65, 7, 30};
    logic [7:0]  phase_color [N_PHASES] = '{8'h00, 8'hA5, 8'h5A, 8'h3C, 8'h07};

    // Blank a run of cells with the current default color
    function automatic void blank_cells(int first, int count);
        for (int i = first; i < first + count; i++) begin
            screen_char[i]  = '0;
            screen_color[i] = shadow_color;
        end
    endfunction

    // Wrap the column and scroll the screen once the cursor runs off it
    function automatic void settle_shadow_cursor();
        if (shadow_col >= COLUMNS) begin
            shadow_col = 0;
            shadow_row++;
        end
        if (shadow_row >= ROWS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++) begin
                screen_char[i]  = screen_char[i + COLUMNS];
                screen_color[i] = screen_color[i + COLUMNS];
            end
            blank_cells(CELLS - COLUMNS, COLUMNS);
            shadow_row = ROWS - 1;
        end
    endfunction

    function automatic void print_glyph(logic [CHR_W-1:0] c);
        screen_char[shadow_row * COLUMNS + shadow_col] = c;
        shadow_col++;
        settle_shadow_cursor();
    endfunction

    // Apply one transaction to the shadow screen and form the result it produces
    function automatic t_console_res predict_console(t_console_cmd cmd);
        t_console_res r;
        int           spaces;
        r.cell_char  = '0;
        r.cell_color = '0;
        case (cmd.action)
            ACT_PUT: begin
                if (cmd.chr == CHR_NL) begin
                    shadow_col = 0;
                    shadow_row++;
                    settle_shadow_cursor();
                end else if (cmd.chr == CHR_CR) begin
                    shadow_col = 0;
                end else if (cmd.chr == CHR_TAB) begin
                    // fix the space count on arrival; each space wraps on its own
                    spaces = TAB_STOP - (shadow_col % TAB_STOP);
                    for (int i = 0; i < spaces; i++) print_glyph(CHR_SPACE);
                end else begin
                    print_glyph(cmd.chr);
                end
            end
            ACT_CLEAR: begin
                blank_cells(0, CELLS);
                shadow_col = 0;
                shadow_row = 0;
            end
            ACT_READ: begin
                if (cmd.col < COLUMNS && cmd.row < ROWS) begin
                    r.cell_char  = screen_char[cmd.row * COLUMNS + cmd.col];
                    r.cell_color = screen_color[cmd.row * COLUMNS + cmd.col];
                end
            end
            default: begin
            end
        endcase
        r.cursor_col    = COL_W'(shadow_col);
        r.cursor_row    = ROW_W'(shadow_row);
        r.cursor_offset = OFF_W'(shadow_row * COLUMNS + shadow_col);
        return r;
    endfunction

    // Drive the input channel from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) expected_res.push_back(predict_console(offered_cmd));
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                offered_cmd = pending_cmds.pop_front();
                i_in_valid  <= 1'b1;
                i_action    <= offered_cmd.action;
                i_chr       <= offered_cmd.chr;
                i_cell_col  <= offered_cmd.col;
                i_cell_row  <= offered_cmd.row;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Throttle the result channel; a requested hold-off overrides random stalls
    always @(posedge i_clk) begin
        if (long_hold_req) begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_console_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_res.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual col %0d row %0d",
                         $time, o_cursor_col, o_cursor_row);
                fail_count++;
            end else begin
                want = expected_res.pop_front();
                check_field("cursor_col", want.cursor_col, o_cursor_col);
                check_field("cursor_row", want.cursor_row, o_cursor_row);
                check_field("cursor_offset", want.cursor_offset, o_cursor_offset);
                check_field("cell_char", want.cell_char, o_cell_char);
                check_field("cell_color", want.cell_color, o_cell_color);
            end
        end
    end

    task automatic queue_cmd(t_action a, logic [CHR_W-1:0] c, logic [COL_W-1:0] col,
                             logic [ROW_W-1:0] row);
        t_console_cmd cmd;
        cmd.action = a;
        cmd.chr    = c;
        cmd.col    = col;
        cmd.row    = row;
        pending_cmds.push_back(cmd);
    endtask

    task automatic queue_put(logic [CHR_W-1:0] c);
        queue_cmd(ACT_PUT, c, COL_W'($urandom), ROW_W'($urandom));
    endtask

    task automatic queue_read(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
        queue_cmd(ACT_READ, CHR_W'($urandom), col, row);
    endtask

    // Wait until nothing is queued, offered or outstanding
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || i_in_valid || expected_res.size() != 0);
    endtask

    task automatic write_default_color(logic [CHR_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_color = v;
    endtask

    // Build one random phase out of text runs, newline bursts, reads, clears and noise
    task automatic gen_phase(int n_items);
        int               made;
        int               kind;
        int               len;
        int               pick;
        logic [CHR_W-1:0] c;
        t_action          a;
        made = 0;
        while (made < n_items) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                len = $urandom_range(100, 1);
                for (int i = 0; i < len; i++) begin
                    pick = $urandom_range(99);
                    if (pick < 8) c = CHR_TAB;
                    else if (pick < 12) c = CHR_CR;
                    else if (pick < 14 && newline_budget > 0) c = CHR_NL;
                    else c = CHR_W'($urandom);
                    if (c == CHR_NL) newline_budget--;
                    queue_put(c);
                end
                made += len;
            end else if (kind < 60 && newline_budget >= 30) begin
                // long enough to reach the bottom row and scroll from any row below the top five
                len = $urandom_range(30, 20);
                for (int i = 0; i < len; i++) queue_put(CHR_NL);
                newline_budget -= len;
                made += len;
            end else if (kind < 88) begin
                len = $urandom_range(10, 1);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(99) < 85)
                        queue_read(COL_W'($urandom_range(COLUMNS - 1)),
                                   ROW_W'($urandom_range(ROWS - 1)));
                    else
                        queue_read(COL_W'($urandom), ROW_W'($urandom));
                end
                made += len;
            end else if (kind < 94 && clear_budget > 0) begin
                queue_cmd(ACT_CLEAR, CHR_W'($urandom), COL_W'($urandom), ROW_W'($urandom));
                clear_budget--;
                made++;
            end else begin
                len = $urandom_range(5, 1);
                for (int i = 0; i < len; i++) begin
                    a = t_action'($urandom_range(3));
                    if (a == ACT_CLEAR) a = ACT_NONE;
                    if (a == ACT_PUT && newline_budget <= 0) a = ACT_READ;
                    c = CHR_W'($urandom);
                    if (a == ACT_PUT && c == CHR_NL) newline_budget--;
                    queue_cmd(a, c, COL_W'($urandom), ROW_W'($urandom));
                    if (a != ACT_NONE) made++;
                end
            end
        end
    endtask

    // Main sequence: reset, directed checks, random phases, drain
    initial begin
        shadow_color = DEFAULT_COLOR_RST;
        blank_cells(0, CELLS);
        shadow_col = 0;
        shadow_row = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // let the power-up sweep finish before touching the register
        repeat (2) @(posedge i_clk);
        do @(negedge i_clk);
        while (o_in_ready !== 1'b1);
        write_default_color(8'hFF);

        // Directed: reads at corners and out of range, control bytes, clear
        queue_read(7'd0, 5'd0);
        queue_read(COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
        queue_read(COL_W'(COLUMNS), 5'd0);
        queue_read(7'd0, ROW_W'(ROWS));
        queue_read(7'h7F, 5'h1F);
        queue_put(8'h41);
        queue_put(8'h00);
        queue_put(8'hFF);
        queue_put(CHR_TAB);
        queue_put(CHR_TAB);
        queue_read(7'd3, 5'd0);
        queue_put(CHR_CR);
        queue_put(CHR_NL);
        queue_cmd(ACT_NONE, 8'hFF, 7'h7F, 5'h1F);
        queue_read(7'd0, 5'd0);
        queue_cmd(ACT_CLEAR, 8'h00, 7'h00, 5'h00);
        queue_read(7'd0, 5'd0);
        queue_put(8'h5A);
        queue_read(7'd0, 5'd0);
        queue_put(CHR_SPACE);
        wait_idle();

        for (int p = 0; p < N_PHASES; p++) begin
            write_default_color(p == 3 ? CHR_W'($urandom) : phase_color[p]);
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            // hold the result channel while the sender keeps pushing
            if (p == 2) long_hold_req = 1'b1;
            gen_phase(PHASE_ITEMS);
            wait_idle();
        end

        repeat (2100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_ctrl.sv
hdl/text_console_writer.sv
dv/tb_text_console_writer.sv
